// File: rtl/i2cm_pkg.sv
// Package: bus phase codes and command codes for the I2C register-access master.
`timescale 1ns / 1ps

package i2cm_pkg;

  // Item command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Bus phase of the transaction sequencer
  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_START_A  = 5'd1,
    PH_START_B  = 5'd2,
    PH_DEV_HI   = 5'd3,
    PH_DEV_LO   = 5'd4,
    PH_REG_HI   = 5'd5,
    PH_REG_LO   = 5'd6,
    PH_DAT_HI   = 5'd7,
    PH_DAT_LO   = 5'd8,
    PH_RDEV_HI  = 5'd9,
    PH_RDEV_LO  = 5'd10,
    PH_RX_HI    = 5'd11,
    PH_RX_LO    = 5'd12,
    PH_RETRY_A  = 5'd13,
    PH_RETRY_B  = 5'd14,
    PH_RSTART_A = 5'd15,
    PH_RSTART_B = 5'd16,
    PH_MID_A    = 5'd17,
    PH_MID_B    = 5'd18,
    PH_FIN_A    = 5'd19,
    PH_FIN_B    = 5'd20
  } phase_t;

  // Index of the ninth (acknowledge) slot within a byte
  localparam logic [3:0] ACK_SLOT = 4'd8;

endpackage

// File: rtl/i2c_master_register_access.sv
// Top level: bit-slot I2C master for single-byte register writes and reads.
//
//  channel | direction | fields                                           | handshake
//  --------+-----------+--------------------------------------------------+------------------
//  in      | input     | cmd device_addr reg_addr write_data sda_in scl_in | in_valid/in_ready
//  out     | output    | scl_out sda_out busy_res done_res read_data       | out_valid/out_ready
//
// Every transfer on the input gives exactly one result transfer; one item per cycle while out_ready stays high.
// The sequencer state and the result register update together in the accepting cycle,
// so the result of an item is offered on the cycle after it is taken.
// A new item is taken while the result register is empty or being drained.
// Reset (rst, synchronous) leaves the bus released, the sequencer idle, no result held.
`timescale 1ns / 1ps

module i2c_master_register_access
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] device_addr,
  input  logic [7:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic       sda_in,
  input  logic       scl_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scl_out,
  output logic       sda_out,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] read_data
);

  phase_t     phase, phase_next;
  logic [3:0] bit_index, bit_index_next;
  logic       is_read, is_read_next;
  logic [7:0] dev_latch, dev_latch_next;
  logic [7:0] reg_latch, reg_latch_next;
  logic [7:0] data_latch, data_latch_next;
  logic [7:0] rx_shift, rx_shift_next;
  logic       ack_bit, ack_bit_next;
  logic       scl_drive, scl_drive_next;
  logic       sda_drive, sda_drive_next;
  logic       done_next;
  logic       done;
  logic       accept;
  logic [7:0] tx_byte;
  logic [2:0] bit_sel;

  // Take an item whenever the result slot is free or emptying
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Result fields follow the registered state of the last transfer
  assign scl_out   = scl_drive;
  assign sda_out   = sda_drive;
  assign busy_res  = (phase != PH_IDLE);
  assign done_res  = done;
  assign read_data = rx_shift;

  // Select the byte being shifted out and the bit within it, MSB first
  always_comb begin
    unique case (phase)
      PH_DEV_HI: tx_byte = dev_latch;
      PH_REG_HI: tx_byte = reg_latch;
      PH_DAT_HI: tx_byte = data_latch;
      default:   tx_byte = dev_latch + 8'd1;
    endcase
    bit_sel = ~bit_index[2:0];
  end

  // Next state of the sequencer for one item
  always_comb begin
    phase_next      = phase;
    bit_index_next  = bit_index;
    is_read_next    = is_read;
    dev_latch_next  = dev_latch;
    reg_latch_next  = reg_latch;
    data_latch_next = data_latch;
    rx_shift_next   = rx_shift;
    ack_bit_next    = ack_bit;
    scl_drive_next  = scl_drive;
    sda_drive_next  = sda_drive;
    done_next       = 1'b0;

    if (phase == PH_IDLE) begin
      // Latch a new transaction
      if (cmd == CMD_WRITE || cmd == CMD_READ) begin
        dev_latch_next  = device_addr;
        reg_latch_next  = reg_addr;
        data_latch_next = write_data;
        is_read_next    = (cmd == CMD_READ);
        bit_index_next  = '0;
        phase_next      = PH_START_A;
      end
    end else if (cmd == CMD_TICK) begin
      unique case (phase)
        PH_START_A, PH_RSTART_A: begin
          // Hold off start until both lines read high
          if (scl_in && sda_in) begin
            scl_drive_next = 1'b1;
            sda_drive_next = 1'b0;
            phase_next     = (phase == PH_START_A) ? PH_START_B : PH_RSTART_B;
          end
        end
        PH_START_B, PH_RSTART_B: begin
          scl_drive_next = 1'b0;
          bit_index_next = '0;
          phase_next     = (phase == PH_START_B) ? PH_DEV_HI : PH_RDEV_HI;
        end
        PH_DEV_HI, PH_REG_HI, PH_DAT_HI, PH_RDEV_HI: begin
          // Drive a data bit, or release SDA and sample the acknowledge
          if (bit_index < ACK_SLOT) begin
            sda_drive_next = tx_byte[bit_sel];
          end else begin
            sda_drive_next = 1'b1;
            ack_bit_next   = sda_in;
          end
          scl_drive_next = 1'b1;
          unique case (phase)
            PH_DEV_HI: phase_next = PH_DEV_LO;
            PH_REG_HI: phase_next = PH_REG_LO;
            PH_DAT_HI: phase_next = PH_DAT_LO;
            default:   phase_next = PH_RDEV_LO;
          endcase
        end
        PH_DEV_LO, PH_REG_LO, PH_DAT_LO, PH_RDEV_LO: begin
          scl_drive_next = 1'b0;
          if (bit_index < ACK_SLOT) begin
            // Advance to the next bit of the same byte
            bit_index_next = bit_index + 4'd1;
            unique case (phase)
              PH_DEV_LO: phase_next = PH_DEV_HI;
              PH_REG_LO: phase_next = PH_REG_HI;
              PH_DAT_LO: phase_next = PH_DAT_HI;
              default:   phase_next = PH_RDEV_HI;
            endcase
          end else begin
            // Byte finished: branch on what follows it
            bit_index_next = '0;
            unique case (phase)
              PH_DEV_LO: phase_next = ack_bit ? PH_RETRY_A : PH_REG_HI;
              PH_REG_LO: phase_next = is_read ? PH_MID_A : PH_DAT_HI;
              PH_DAT_LO: phase_next = PH_FIN_A;
              default: begin
                rx_shift_next = '0;
                phase_next    = PH_RX_HI;
              end
            endcase
          end
        end
        PH_RX_HI: begin
          // Sample a received bit; the ninth slot is our NACK
          scl_drive_next = 1'b1;
          sda_drive_next = 1'b1;
          if (bit_index < ACK_SLOT && sda_in) begin
            rx_shift_next[bit_sel] = 1'b1;
          end
          phase_next = PH_RX_LO;
        end
        PH_RX_LO: begin
          scl_drive_next = 1'b0;
          if (bit_index < ACK_SLOT) begin
            bit_index_next = bit_index + 4'd1;
            phase_next     = PH_RX_HI;
          end else begin
            bit_index_next = '0;
            phase_next     = PH_FIN_A;
          end
        end
        PH_RETRY_A, PH_MID_A, PH_FIN_A: begin
          // Raise SCL with SDA low ahead of a stop
          scl_drive_next = 1'b1;
          sda_drive_next = 1'b0;
          unique case (phase)
            PH_RETRY_A: phase_next = PH_RETRY_B;
            PH_MID_A:   phase_next = PH_MID_B;
            default:    phase_next = PH_FIN_B;
          endcase
        end
        PH_RETRY_B: begin
          sda_drive_next = 1'b1;
          phase_next     = PH_START_A;
        end
        PH_MID_B: begin
          sda_drive_next = 1'b1;
          phase_next     = PH_RSTART_A;
        end
        PH_FIN_B: begin
          sda_drive_next = 1'b1;
          phase_next     = PH_IDLE;
          done_next      = 1'b1;
        end
        default: begin
          // Drop back to idle from any stray code
          scl_drive_next = 1'b1;
          sda_drive_next = 1'b1;
          bit_index_next = '0;
          phase_next     = PH_IDLE;
        end
      endcase
    end
  end

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_index  <= '0;
      is_read    <= 1'b0;
      dev_latch  <= '0;
      reg_latch  <= '0;
      data_latch <= '0;
      rx_shift   <= '0;
      ack_bit    <= 1'b1;
      scl_drive  <= 1'b1;
      sda_drive  <= 1'b1;
      done       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        bit_index  <= bit_index_next;
        is_read    <= is_read_next;
        dev_latch  <= dev_latch_next;
        reg_latch  <= reg_latch_next;
        data_latch <= data_latch_next;
        rx_shift   <= rx_shift_next;
        ack_bit    <= ack_bit_next;
        scl_drive  <= scl_drive_next;
        sda_drive  <= sda_drive_next;
        done       <= done_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
